/* rtl/rqsf_pkg.sv */
// Shared types, constants and helpers for the request queue block.
// Holds the queue depth, field widths, status and register codes, the scan
// control word and the slot pointer wrap function. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rqsf_pkg;

	// Built queue depth and the widths that follow from it
	localparam int DEPTH = 16;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	// Fixed field widths
	localparam int TAG_W   = 32;
	localparam int SIZE_W  = 32;
	localparam int ENTRY_W = TAG_W + SIZE_W;
	localparam int OCC_W   = 5;
	localparam int CFG_W   = 5;
	localparam int IDX_W   = 1;

	// Reset value of the capacity register
	localparam logic [CFG_W-1:0] SLOTS_RESET = 5'd16;

	// Sort key of a request whose size is unknown (any negative size)
	localparam logic [SIZE_W-1:0] UNKNOWN_KEY = 32'h7fff_ffff;

	typedef enum logic [0:0] {
		KIND_PUSH = 1'b0,
		KIND_POP  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_POPPED = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [IDX_W-1:0] {
		REG_SCHED_MODE   = 1'b0,
		REG_SLOTS_IN_USE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	// Control word from the sequencer to the compare unit
	typedef struct packed {
		logic step;   // read data is valid this cycle
		logic first;  // read data is the head slot
	} cmp_ctl_t;

	// Advance a slot pointer by one, wrapping at the capacity in use
	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] pos,
			input logic [CW-1:0] cap);
		logic [CW-1:0] inc;
		inc = CW'(pos) + 1'b1;
		return (inc == cap) ? '0 : AW'(inc);
	endfunction

	// Sort key of a stored size: negative sizes sort last
	function automatic logic [SIZE_W-1:0] size_key(input logic [SIZE_W-1:0] size);
		return size[SIZE_W-1] ? UNKNOWN_KEY : size;
	endfunction

endpackage

`default_nettype wire

/* rtl/rqsf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the request slot store. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module rqsf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word and read one word, with the read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/rqsf_cmp.sv */
// Shared key compare unit: keeps the smallest-key word seen during a scan,
// its slot address and the head slot word. Depends on rqsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rqsf_cmp (
	input  logic                         clk,
	input  rqsf_pkg::cmp_ctl_t           ctl,
	input  logic [rqsf_pkg::AW-1:0]      addr,
	input  logic [rqsf_pkg::ENTRY_W-1:0] rdata,
	output logic [rqsf_pkg::ENTRY_W-1:0] best_entry,
	output logic [rqsf_pkg::AW-1:0]      pick_addr,
	output logic [rqsf_pkg::ENTRY_W-1:0] head_entry
);

	import rqsf_pkg::*;

	logic [ENTRY_W-1:0] best_q;
	logic [AW-1:0]      pick_q;
	logic [ENTRY_W-1:0] head_q;
	logic [SIZE_W-1:0]  key_in;
	logic [SIZE_W-1:0]  key_best;
	logic               take;

	// Strictly smaller key wins, so ties stay with the older word
	assign key_in   = size_key(rdata[ENTRY_W-1:TAG_W]);
	assign key_best = size_key(best_q[ENTRY_W-1:TAG_W]);
	assign take     = ctl.first || (key_in < key_best);

	// Hold the best candidate and the head word
	always_ff @(posedge clk) begin
		if (ctl.step && take) begin
			best_q <= rdata;
			pick_q <= addr;
		end
		if (ctl.step && ctl.first) begin
			head_q <= rdata;
		end
	end

	assign best_entry = best_q;
	assign pick_addr  = pick_q;
	assign head_entry = head_q;

endmodule

`default_nettype wire

/* rtl/request_queue_fifo_or_smallest_first.sv */
// Request queue with oldest-first or smallest-size-first pop.
//
// Command channel: a word (kind, request_tag, file_size) is taken at a rising
// edge with start high and busy low. Every word gives exactly one result,
// shown for one cycle with done high: status, out_tag, out_size, occupancy.
// The receiver cannot stall; results are never held back or repeated.
//
// Sequencing and throughput:
//   push, refused push, refused pop: result in the cycle after acceptance,
//     busy stays low, so one such word per cycle.
//   pop, oldest first: busy in S_SCAN and S_FINISH, result registered from S_FINISH.
//   pop, smallest first: busy in S_SCAN while each of the fill slots is
//     read and compared, then in S_FINISH, result registered from S_FINISH;
//     fill being the occupancy before the pop. The slot memory has one read
//     port and one compare unit, so one slot is examined per cycle.
// Configuration: cfg_we writes sched_mode (index 0) or slots_in_use
// (index 1) at once; a capacity write empties the queue. Write only while
// idle.
// Reset: queue empty, oldest-first mode, capacity 16. The slot memory needs
// no clearing pass; only data of written slots is ever used.
`timescale 1ns / 1ps
`default_nettype none

module request_queue_fifo_or_smallest_first (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic [rqsf_pkg::TAG_W-1:0]        request_tag,
	input  logic signed [rqsf_pkg::SIZE_W-1:0] file_size,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [rqsf_pkg::TAG_W-1:0]        out_tag,
	output logic signed [rqsf_pkg::SIZE_W-1:0] out_size,
	output logic [rqsf_pkg::OCC_W-1:0]        occupancy,
	input  logic                              cfg_we,
	input  logic [rqsf_pkg::IDX_W-1:0]        cfg_index,
	input  logic [rqsf_pkg::CFG_W-1:0]        cfg_data
);

	import rqsf_pkg::*;

	// Control and configuration registers
	state_t           state_q, state_d;
	logic             mode_q;
	logic [CFG_W-1:0] slots_q;
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    tail_q;
	logic [CW-1:0]    fill_q;
	logic [AW-1:0]    cur_q;
	logic [CW-1:0]    left_q;
	logic             first_q;

	// Result registers
	logic               done_q;
	status_t            status_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [OCC_W-1:0]   occ_q;

	// Datapath nets
	logic [CW-1:0]      cap_w;
	logic               full_w;
	logic               empty_w;
	logic               accept_w;
	logic [AW-1:0]      cur_next_w;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	cmp_ctl_t           cmp_ctl;
	logic [ENTRY_W-1:0] best_entry;
	logic [AW-1:0]      pick_addr;
	logic [ENTRY_W-1:0] head_entry;

	// Sequencer decisions
	logic    do_push;
	logic    do_pop_start;
	logic    do_scan_step;
	logic    do_finish;
	logic    res_valid;
	status_t res_status;

	// Clamp the capacity to 1 .. DEPTH
	always_comb begin
		if (slots_q == '0) begin
			cap_w = CW'(1);
		end else if (32'(slots_q) > 32'(DEPTH)) begin
			cap_w = CW'(DEPTH);
		end else begin
			cap_w = CW'(slots_q);
		end
	end

	assign full_w     = (fill_q >= cap_w);
	assign empty_w    = (fill_q == '0);
	assign busy       = (state_q != S_IDLE);
	assign accept_w   = start && !busy;
	assign cur_next_w = next_slot(cur_q, cap_w);

	// Next state and sequencer strobes
	always_comb begin
		state_d      = state_q;
		do_push      = 1'b0;
		do_pop_start = 1'b0;
		do_scan_step = 1'b0;
		do_finish    = 1'b0;
		res_valid    = 1'b0;
		res_status   = ST_PUSHED;
		cmp_ctl      = '0;
		case (state_q)
			S_IDLE: begin
				if (accept_w) begin
					if (kind == KIND_PUSH) begin
						res_valid = 1'b1;
						if (full_w) begin
							res_status = ST_FULL;
						end else begin
							res_status = ST_PUSHED;
							do_push    = 1'b1;
						end
					end else if (empty_w) begin
						res_valid  = 1'b1;
						res_status = ST_EMPTY;
					end else begin
						do_pop_start = 1'b1;
						state_d      = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmp_ctl.step  = 1'b1;
				cmp_ctl.first = first_q;
				if (left_q != '0) begin
					do_scan_step = 1'b1;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				do_finish  = 1'b1;
				res_valid  = 1'b1;
				res_status = ST_POPPED;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Slot memory ports: push writes at the tail, a finished pop moves the
	// head word into the picked slot
	always_comb begin
		ram_we    = do_push || do_finish;
		ram_waddr = do_finish ? pick_addr : tail_q;
		ram_wdata = do_finish ? head_entry : {file_size, request_tag};
		ram_raddr = (state_q == S_SCAN) ? cur_next_w : head_q;
	end

	rqsf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rqsf_cmp u_cmp (
		.clk        (clk),
		.ctl        (cmp_ctl),
		.addr       (cur_q),
		.rdata      (ram_rdata),
		.best_entry (best_entry),
		.pick_addr  (pick_addr),
		.head_entry (head_entry)
	);

	// State, pointers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= 1'b0;
			slots_q <= SLOTS_RESET;
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			cur_q   <= '0;
			left_q  <= '0;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_push) begin
				tail_q <= next_slot(tail_q, cap_w);
				fill_q <= fill_q + 1'b1;
			end
			if (do_pop_start) begin
				cur_q   <= head_q;
				left_q  <= mode_q ? (fill_q - 1'b1) : '0;
				first_q <= 1'b1;
			end
			if (do_scan_step) begin
				cur_q   <= cur_next_w;
				left_q  <= left_q - 1'b1;
				first_q <= 1'b0;
			end
			if (do_finish) begin
				head_q <= next_slot(head_q, cap_w);
				fill_q <= fill_q - 1'b1;
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_SCHED_MODE: begin
						mode_q <= cfg_data[0];
					end
					REG_SLOTS_IN_USE: begin
						slots_q <= cfg_data;
						head_q  <= '0;
						tail_q  <= '0;
						fill_q  <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_valid;
		end
	end

	// Result word; the occupancy counts the change made by this word
	always_ff @(posedge clk) begin
		if (res_valid) begin
			status_q <= res_status;
			entry_q  <= do_finish ? best_entry : '0;
			if (do_push) begin
				occ_q <= OCC_W'(fill_q + 1'b1);
			end else if (do_finish) begin
				occ_q <= OCC_W'(fill_q - 1'b1);
			end else begin
				occ_q <= OCC_W'(fill_q);
			end
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign out_tag   = entry_q[TAG_W-1:0];
	assign out_size  = $signed(entry_q[ENTRY_W-1:TAG_W]);
	assign occupancy = occ_q;

	// Expected tail from head and fill, for the pointer check
	logic [CW:0] tail_sum_w;
	logic [CW:0] tail_wrap_w;

	assign tail_sum_w  = (CW+1)'(head_q) + (CW+1)'(fill_q);
	assign tail_wrap_w = (tail_sum_w >= (CW+1)'(cap_w)) ?
		(tail_sum_w - (CW+1)'(cap_w)) : tail_sum_w;

	// The queue never holds more than its capacity
	a_fill_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_w)
		else $error("fill count above capacity");

	// Head, tail and fill agree around the ring
	a_ptr_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q == AW'(tail_wrap_w))
		else $error("tail pointer disagrees with head and fill");

	// A result never appears while a pop is still in progress
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// A started pop always delivers a popped word, never a refusal
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) |=> (done && status == ST_POPPED))
		else $error("pop finished without a popped result");

endmodule

`default_nettype wire

/* tb/request_queue_fifo_or_smallest_first_test.sv */
// Self-checking bench for the request queue block.
// Drives push and pop words, predicts every result and compares each one.
// Depends on rqsf_pkg and request_queue_fifo_or_smallest_first.
`timescale 1ns / 1ps

module request_queue_fifo_or_smallest_first_test;

	import rqsf_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int END_WAIT    = 24;
	localparam int PRINT_CAP   = 100;

	typedef struct {
		status_t            status;
		logic [TAG_W-1:0]   tag;
		logic [SIZE_W-1:0]  size;
		logic [OCC_W-1:0]   occ;
	} queue_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      kind;
	logic [TAG_W-1:0]          request_tag;
	logic signed [SIZE_W-1:0]  file_size;
	logic                      done;
	logic [1:0]                status;
	logic [TAG_W-1:0]          out_tag;
	logic signed [SIZE_W-1:0]  out_size;
	logic [OCC_W-1:0]          occupancy;
	logic                      cfg_we;
	reg_idx_t                  cfg_index;
	logic [CFG_W-1:0]          cfg_data;

	// Shadow of the queue kept by the predictor
	logic [TAG_W-1:0]          shadow_tag [DEPTH];
	logic [SIZE_W-1:0]         shadow_size [DEPTH];
	int                        shadow_head;
	int                        shadow_tail;
	int                        shadow_fill;
	logic                      shadow_mode;
	logic [CFG_W-1:0]          shadow_slots;

	queue_result_t             pending_results [$];
	int                        mismatches;
	int                        cycle_count;
	int                        idle_pct;

	request_queue_fifo_or_smallest_first uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.request_tag (request_tag),
		.file_size   (file_size),
		.done        (done),
		.status      (status),
		.out_tag     (out_tag),
		.out_size    (out_size),
		.occupancy   (occupancy),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
	endtask

	// Negative sizes sort as the largest key
	function automatic logic [SIZE_W-1:0] order_key(logic [SIZE_W-1:0] size);
		return size[SIZE_W-1] ? UNKNOWN_KEY : size;
	endfunction

	function automatic int capacity_in_use();
		if (shadow_slots == 0)
			return 1;
		if (shadow_slots > DEPTH)
			return DEPTH;
		return shadow_slots;
	endfunction

	// Advance the shadow queue by one word and queue the result it gives
	task automatic predict_queue_word(kind_t k, logic [TAG_W-1:0] tag,
			logic [SIZE_W-1:0] size);
		queue_result_t r;
		int cap;
		int h;
		int pick;
		int idx;
		logic [SIZE_W-1:0] best;
		logic [TAG_W-1:0] keep_tag;
		logic [SIZE_W-1:0] keep_size;
		cap = capacity_in_use();
		r.tag = '0;
		r.size = '0;
		if (k == KIND_PUSH) begin
			if (shadow_fill >= cap) begin
				r.status = ST_FULL;
			end else begin
				shadow_tail = shadow_tail % cap;
				shadow_tag[shadow_tail] = tag;
				shadow_size[shadow_tail] = size;
				shadow_tail = (shadow_tail + 1) % cap;
				shadow_fill++;
				r.status = ST_PUSHED;
			end
		end else if (shadow_fill == 0) begin
			r.status = ST_EMPTY;
		end else begin
			h = shadow_head % cap;
			pick = h;
			// Scan oldest to newest; strict compare keeps the older on a tie
			if (shadow_mode) begin
				best = order_key(shadow_size[h]);
				for (int k2 = 1; k2 < shadow_fill && k2 < cap; k2++) begin
					idx = (h + k2) % cap;
					if (order_key(shadow_size[idx]) < best) begin
						best = order_key(shadow_size[idx]);
						pick = idx;
					end
				end
			end
			keep_tag = shadow_tag[pick];
			keep_size = shadow_size[pick];
			shadow_tag[pick] = shadow_tag[h];
			shadow_size[pick] = shadow_size[h];
			shadow_tag[h] = keep_tag;
			shadow_size[h] = keep_size;
			r.tag = keep_tag;
			r.size = keep_size;
			shadow_head = (h + 1) % cap;
			shadow_fill--;
			r.status = ST_POPPED;
		end
		r.occ = OCC_W'(shadow_fill);
		pending_results.push_back(r);
	endtask

	// Compare each result word with the oldest prediction
	always @(posedge clk) begin : result_check
		queue_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", 32'(status), 32'h0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (out_tag !== want.tag)
					report_mismatch("out_tag", out_tag, want.tag);
				if (out_size !== want.size)
					report_mismatch("out_size", out_size, want.size);
				if (occupancy !== want.occ)
					report_mismatch("occupancy", 32'(occupancy), 32'(want.occ));
			end
		end
	end

	// Offer one word, hold it until taken, then maybe leave a gap
	task automatic send_word(kind_t k, logic [TAG_W-1:0] tag, logic [SIZE_W-1:0] size);
		start = 1'b1;
		kind = k;
		request_tag = tag;
		file_size = size;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_queue_word(k, tag, size);
		@(negedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 4))
				@(negedge clk);
		end
	endtask

	// Hold off new words until every predicted result has come back
	task automatic hold_until_drained();
		start = 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(reg_idx_t idx, logic [CFG_W-1:0] value);
		hold_until_drained();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_SCHED_MODE) begin
			shadow_mode = value[0];
		end else begin
			shadow_slots = value;
			shadow_head = 0;
			shadow_tail = 0;
			shadow_fill = 0;
		end
	endtask

	function automatic logic [SIZE_W-1:0] random_size();
		case ($urandom_range(0, 9))
			0: return '1;
			1: return $urandom | 32'h8000_0000;
			2: return '0;
			3: return 32'h7fff_ffff;
			4, 5: return $urandom_range(0, 7);
			6: return $urandom_range(0, 1000);
			default: return $urandom & 32'h7fff_ffff;
		endcase
	endfunction

	// Refused pop, then pushes over the size extremes and one oldest-first pop
	task automatic test_empty_and_fifo();
		send_word(KIND_POP, 32'h0, 32'h0);
		send_word(KIND_PUSH, 32'h0000_0000, 32'h0000_0000);
		send_word(KIND_PUSH, 32'hffff_ffff, 32'h7fff_ffff);
		send_word(KIND_PUSH, 32'ha5a5_a5a5, 32'hffff_ffff);
		send_word(KIND_PUSH, 32'h5a5a_5a5a, 32'h8000_0000);
		send_word(KIND_PUSH, 32'h0000_1234, 32'd5);
		send_word(KIND_POP, 32'hdead_beef, 32'd9);
	endtask

	// Smallest first: unknown and other negative sizes sort last, older wins ties
	task automatic test_smallest_first();
		write_register(REG_SCHED_MODE, 5'd1);
		repeat (4)
			send_word(KIND_POP, $urandom, $urandom);
		send_word(KIND_PUSH, 32'h0000_0011, 32'd3);
		send_word(KIND_PUSH, 32'h0000_0022, 32'd3);
		repeat (3)
			send_word(KIND_POP, $urandom, $urandom);
	endtask

	// Capacity clamping, refused push on full, and a capacity write emptying the queue
	task automatic test_capacity();
		write_register(REG_SLOTS_IN_USE, 5'd0);
		send_word(KIND_PUSH, 32'h0000_0101, 32'd1);
		send_word(KIND_PUSH, 32'h0000_0102, 32'd2);
		send_word(KIND_POP, 32'h0, 32'h0);
		write_register(REG_SLOTS_IN_USE, 5'd31);
		write_register(REG_SCHED_MODE, 5'b11110);
		send_word(KIND_PUSH, 32'h0000_0201, 32'd7);
		write_register(REG_SLOTS_IN_USE, 5'd2);
		send_word(KIND_POP, 32'h0, 32'h0);
		repeat (3)
			send_word(KIND_PUSH, $urandom, random_size());
		send_word(KIND_POP, 32'h0, 32'h0);
	endtask

	// Bursts of mostly pushes, mostly pops or an even mix so the queue swings between empty and full
	task automatic test_random_traffic(int words, int gap);
		int sent;
		int burst;
		int push_pct;
		kind_t k;
		idle_pct = gap;
		sent = 0;
		while (sent < words) begin
			case ($urandom_range(0, 2))
				0: push_pct = 20;
				1: push_pct = 50;
				default: push_pct = 85;
			endcase
			burst = $urandom_range(4, 40);
			while (burst > 0 && sent < words) begin
				if (sent == words / 2)
					hold_until_drained();
				k = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
				send_word(k, $urandom, random_size());
				sent++;
				burst--;
			end
		end
	endtask

	task automatic test_random_phases();
		logic [CFG_W-1:0] mode_data [6];
		logic [CFG_W-1:0] slot_data [6];
		int gap_data [6];
		mode_data = '{5'd1, 5'd2, 5'd3, 5'd0, 5'd31, 5'd1};
		slot_data = '{5'd16, 5'd7, 5'd3, 5'd31, 5'd16, 5'd12};
		gap_data = '{11, 11, 88, 88, 0, 0};
		for (int p = 0; p < 6; p++) begin
			write_register(REG_SCHED_MODE, mode_data[p]);
			// The capacity write comes with any words left queued by the last phase
			write_register(REG_SLOTS_IN_USE, slot_data[p]);
			test_random_traffic(255, gap_data[p]);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_PUSH;
		request_tag = '0;
		file_size = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SCHED_MODE;
		cfg_data = '0;
		mismatches = 0;
		cycle_count = 0;
		idle_pct = 0;
		shadow_head = 0;
		shadow_tail = 0;
		shadow_fill = 0;
		shadow_mode = 1'b0;
		shadow_slots = SLOTS_RESET;
		for (int i = 0; i < DEPTH; i++) begin
			shadow_tag[i] = '0;
			shadow_size[i] = '0;
		end
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_and_fifo();
		test_smallest_first();
		test_capacity();
		test_random_phases();

		// Drain, then allow for the longest scan before judging
		hold_until_drained();
		repeat (END_WAIT)
			@(negedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/rqsf_pkg.sv
rtl/rqsf_ram.sv
rtl/rqsf_cmp.sv
rtl/request_queue_fifo_or_smallest_first.sv
tb/request_queue_fifo_or_smallest_first_test.sv
